/* rtl/core/grid_ray_dda_caster_macros.svh */
// ----------------------------------------------------------------------------
// Raycaster assertion macros
// Concurrent assertion shorthands shared by the raycaster RTL.
// ----------------------------------------------------------------------------
`ifndef GRID_RAY_DDA_CASTER_MACROS_SVH
`define GRID_RAY_DDA_CASTER_MACROS_SVH
`ifndef SYNTHESIS
`define GRDC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("raycaster assertion failed");
`define GRDC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("raycaster assertion failed");
`else
`define GRDC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GRDC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/grdc_pkg.sv */
// ----------------------------------------------------------------------------
// Raycaster package
// Widths, codes, state type and shared structs of the grid raycaster.
// ----------------------------------------------------------------------------
package grdc_pkg;

	localparam int MAP_COLS  = 32;
	localparam int MAP_ROWS  = 32;
	localparam int MAX_STEPS = 64;

	localparam int MAP_DEPTH = 1024;
	localparam int MAP_AW    = $clog2(MAP_DEPTH);
	localparam int MAP_MAX   = (MAP_COLS > MAP_ROWS) ? MAP_COLS : MAP_ROWS;
	localparam int CRD_W     = $clog2(MAP_MAX + 1) + 1;
	localparam int IDX_W     = $clog2(MAP_COLS * MAP_ROWS) + 2;
	localparam int STEP_W    = $clog2(MAX_STEPS + 1);

	localparam int DIV_N  = 31;
	localparam int DVS_W  = 17;
	localparam int DCNT_W = $clog2(DIV_N);

	localparam logic [2:0] CFG_POS_X   = 3'd0;
	localparam logic [2:0] CFG_POS_Y   = 3'd1;
	localparam logic [2:0] CFG_DIR_X   = 3'd2;
	localparam logic [2:0] CFG_DIR_Y   = 3'd3;
	localparam logic [2:0] CFG_PLANE_X = 3'd4;
	localparam logic [2:0] CFG_PLANE_Y = 3'd5;
	localparam logic [2:0] CFG_SCREEN_W = 3'd6;

	localparam logic [1:0] SIDE_WEST  = 2'd0;
	localparam logic [1:0] SIDE_EAST  = 2'd1;
	localparam logic [1:0] SIDE_SOUTH = 2'd2;
	localparam logic [1:0] SIDE_NORTH = 2'd3;

	localparam logic [1:0] STAT_HIT   = 2'd0;
	localparam logic [1:0] STAT_LEFT  = 2'd1;
	localparam logic [1:0] STAT_LIMIT = 2'd2;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_CAST  = 1'b1;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_CAM_DIV, S_CAM_WAIT, S_MUL_X, S_MUL_Y,
		S_RX_DIV, S_RX_WAIT, S_RY_DIV, S_RY_WAIT, S_SDX_MUL, S_SDY_MUL,
		S_SIDE, S_WALK, S_READ, S_FINISH
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_N-1:0]     dividend;
		logic [DVS_W-1:0]     divisor;
	} div_ctl_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [DIV_N-1:0]     quotient;
	} div_sts_t;

endpackage

/* rtl/core/grdc_if.sv */
// ----------------------------------------------------------------------------
// Raycaster channels
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface grdc_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [9:0]  cell_index;
	logic [7:0]  cell_value;
	logic [11:0] column;
	modport source (output valid, action, cell_index, cell_value, column, input ready);
	modport sink   (input valid, action, cell_index, cell_value, column, output ready);
endinterface

interface grdc_rsp_if;
	logic               valid;
	logic               ready;
	logic [11:0]        column_out;
	logic signed [16:0] ray_dir_x;
	logic signed [16:0] ray_dir_y;
	logic [4:0]         hit_cell_x;
	logic [4:0]         hit_cell_y;
	logic [1:0]         side;
	logic [31:0]        perp_dist;
	logic [7:0]         wall_value;
	logic [1:0]         status;
	modport source (output valid, column_out, ray_dir_x, ray_dir_y, hit_cell_x, hit_cell_y,
		side, perp_dist, wall_value, status, input ready);
	modport sink   (input valid, column_out, ray_dir_x, ray_dir_y, hit_cell_x, hit_cell_y,
		side, perp_dist, wall_value, status, output ready);
endinterface

interface grdc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  reg_index;
	logic [20:0] data;
	modport source (output valid, reg_index, data, input ready);
	modport sink   (input valid, reg_index, data, output ready);
endinterface

/* rtl/core/grdc_div.sv */
// ----------------------------------------------------------------------------
// Raycaster divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grdc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  grdc_pkg::div_ctl_t  ctl,
	output grdc_pkg::div_sts_t  sts
);
	logic [grdc_pkg::DVS_W-1:0]  rem_q;
	logic [grdc_pkg::DIV_N-1:0]  quo_q;
	logic [grdc_pkg::DVS_W-1:0]  dvs_q;
	logic [grdc_pkg::DCNT_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [grdc_pkg::DVS_W:0]    rem_sh;
	logic                        fits;

	assign rem_sh = {rem_q, quo_q[grdc_pkg::DIV_N-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == grdc_pkg::DCNT_W'(grdc_pkg::DIV_N - 1));
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == grdc_pkg::DCNT_W'(grdc_pkg::DIV_N - 1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			quo_q <= ctl.dividend;
			dvs_q <= ctl.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? grdc_pkg::DVS_W'(rem_sh - {1'b0, dvs_q})
				: rem_sh[grdc_pkg::DVS_W-1:0];
			quo_q <= {quo_q[grdc_pkg::DIV_N-2:0], fits};
		end
	end

	assign sts.busy     = busy_q;
	assign sts.done     = done_q;
	assign sts.quotient = quo_q;
endmodule

/* rtl/core/grid_ray_dda_caster.sv */
// ----------------------------------------------------------------------------
// Grid raycaster
// DDA raycaster over a 1024-cell map with a shared serial divider.
// ----------------------------------------------------------------------------
// After reset all 1024 map cells are cleared, one cell per cycle; req is
// not ready meanwhile. A write item is written to the map as it is accepted.
// A cast item runs a setup (three passes through the shared divider for
// camera x and the two reciprocals, plus multiplies and side distances)
// followed by the DDA steps, each a step state and then a map read. req is
// ready again once the result is loaded into the output register, which is
// held off only while a previous result still waits.
// One cast is in flight at a time; its result waits in an output register.
module grid_ray_dda_caster (
	input  logic   clk,
	input  logic   arst_n,
	grdc_req_if.sink   req,
	grdc_rsp_if.source rsp,
	grdc_cfg_if.sink   cfg
);
`include "grid_ray_dda_caster_macros.svh"

	grdc_pkg::state_t state_q, state_d;

	logic [20:0]        pos_x_q, pos_y_q;
	logic signed [15:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
	logic [12:0]        sw_q;

	logic [7:0]  mem [grdc_pkg::MAP_DEPTH];
	logic [7:0]  rdata_q;
	logic        mem_we;
	logic [grdc_pkg::MAP_AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]  mem_wdata;
	logic [grdc_pkg::MAP_AW:0]   clr_q;

	grdc_pkg::div_ctl_t div_ctl;
	grdc_pkg::div_sts_t div_sts;

	logic [11:0]               col_q;
	logic signed [28:0]        cam_q;
	logic signed [50:0]        prod_q;
	logic signed [16:0]        rdx_q, rdy_q;
	logic [31:0]               dx_q, dy_q, sdx_q, sdy_q, perp_q;
	logic signed [grdc_pkg::CRD_W-1:0] cx_q, cy_q;
	logic [grdc_pkg::STEP_W-1:0] step_q;
	logic [1:0]                side_q, stat_q;
	logic [7:0]                wall_q;
	logic                      oob_q;
	logic                      out_valid_q;
	logic                      load_out;

	logic signed [32:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [50:0] mul_p;
	logic signed [37:0] rd_sum;
	logic signed [16:0] rd_sat;
	logic signed [15:0] dir_sel;
	logic [32:0]        sd_raw;
	logic [31:0]        sd_sat;
	logic [16:0]        abs_x, abs_y, fx_sel, fy_sel;
	logic [12:0]        sw_eff;
	logic               take_x, start_in, next_in;
	logic signed [grdc_pkg::CRD_W-1:0] nx, ny;
	logic [grdc_pkg::IDX_W-1:0] nidx;
	logic [32:0]        acc_sum;
	logic [31:0]        acc_sat;
	logic [7:0]         rd_val;

	function automatic logic in_map(logic signed [grdc_pkg::CRD_W-1:0] x,
		logic signed [grdc_pkg::CRD_W-1:0] y);
		return (x >= 0) && (x < grdc_pkg::CRD_W'(grdc_pkg::MAP_COLS)) &&
			(y >= 0) && (y < grdc_pkg::CRD_W'(grdc_pkg::MAP_ROWS));
	endfunction

	grdc_div u_div (.clk(clk), .arst_n(arst_n), .ctl(div_ctl), .sts(div_sts));

	// shared multiplier: plane * camera x, then fraction * delta
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			grdc_pkg::S_MUL_X: begin
				mul_a = 33'(cam_q);
				mul_b = 18'(plane_x_q);
			end
			grdc_pkg::S_MUL_Y: begin
				mul_a = 33'(cam_q);
				mul_b = 18'(plane_y_q);
			end
			grdc_pkg::S_SDX_MUL: begin
				mul_a = $signed({1'b0, dx_q});
				mul_b = $signed({1'b0, fx_sel});
			end
			grdc_pkg::S_SDY_MUL: begin
				mul_a = $signed({1'b0, dy_q});
				mul_b = $signed({1'b0, fy_sel});
			end
			default: ;
		endcase
		mul_p = 51'(mul_a * mul_b);
	end

	assign dir_sel = (state_q == grdc_pkg::S_MUL_Y) ? dir_x_q : dir_y_q;
	assign rd_sum  = 38'(dir_sel) + 38'($signed(prod_q[50:14]));
	assign rd_sat  = (rd_sum < -38'sd65536) ? -17'sd65536 :
		(rd_sum > 38'sd65535) ? 17'sd65535 : rd_sum[16:0];
	assign sd_raw  = prod_q[48:16];
	assign sd_sat  = sd_raw[32] ? 32'hFFFF_FFFF : sd_raw[31:0];

	assign abs_x  = rdx_q[16] ? 17'(-rdx_q) : 17'(rdx_q);
	assign abs_y  = rdy_q[16] ? 17'(-rdy_q) : 17'(rdy_q);
	assign fx_sel = rdx_q[16] ? {1'b0, pos_x_q[15:0]} : 17'(17'h10000 - {1'b0, pos_x_q[15:0]});
	assign fy_sel = rdy_q[16] ? {1'b0, pos_y_q[15:0]} : 17'(17'h10000 - {1'b0, pos_y_q[15:0]});
	assign sw_eff = (sw_q == '0) ? 13'd1 : sw_q;

	// DDA step
	assign take_x  = sdx_q < sdy_q;
	assign nx      = take_x ? (rdx_q[16] ? cx_q - 1'b1 : cx_q + 1'b1) : cx_q;
	assign ny      = take_x ? cy_q : (rdy_q[16] ? cy_q - 1'b1 : cy_q + 1'b1);
	assign nidx    = grdc_pkg::IDX_W'(nx) + grdc_pkg::IDX_W'(ny) *
		grdc_pkg::IDX_W'(grdc_pkg::MAP_COLS);
	assign acc_sum = take_x ? {1'b0, sdx_q} + {1'b0, dx_q} : {1'b0, sdy_q} + {1'b0, dy_q};
	assign acc_sat = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
	assign next_in = in_map(nx, ny);
	assign start_in = in_map(cx_q, cy_q);
	assign rd_val  = oob_q ? 8'd0 : rdata_q;

	assign load_out = (state_q == grdc_pkg::S_FINISH) && (!out_valid_q || rsp.ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			grdc_pkg::S_CLEAR:
				if (clr_q == (grdc_pkg::MAP_AW+1)'(grdc_pkg::MAP_DEPTH - 1)) state_d = grdc_pkg::S_IDLE;
			grdc_pkg::S_IDLE:
				if (req.valid && req.action == grdc_pkg::ACT_CAST) state_d = grdc_pkg::S_CAM_DIV;
			grdc_pkg::S_CAM_DIV:  state_d = grdc_pkg::S_CAM_WAIT;
			grdc_pkg::S_CAM_WAIT: if (div_sts.done) state_d = grdc_pkg::S_MUL_X;
			grdc_pkg::S_MUL_X:    state_d = grdc_pkg::S_MUL_Y;
			grdc_pkg::S_MUL_Y:    state_d = grdc_pkg::S_RX_DIV;
			grdc_pkg::S_RX_DIV:   state_d = grdc_pkg::S_RX_WAIT;
			grdc_pkg::S_RX_WAIT:  if (div_sts.done) state_d = grdc_pkg::S_RY_DIV;
			grdc_pkg::S_RY_DIV:   state_d = grdc_pkg::S_RY_WAIT;
			grdc_pkg::S_RY_WAIT:  if (div_sts.done) state_d = grdc_pkg::S_SDX_MUL;
			grdc_pkg::S_SDX_MUL:  state_d = grdc_pkg::S_SDY_MUL;
			grdc_pkg::S_SDY_MUL:  state_d = grdc_pkg::S_SIDE;
			grdc_pkg::S_SIDE:     state_d = start_in ? grdc_pkg::S_WALK : grdc_pkg::S_FINISH;
			grdc_pkg::S_WALK:
				priority if (step_q == grdc_pkg::STEP_W'(grdc_pkg::MAX_STEPS))
					state_d = grdc_pkg::S_FINISH;
				else if (!next_in) state_d = grdc_pkg::S_FINISH;
				else state_d = grdc_pkg::S_READ;
			grdc_pkg::S_READ:     state_d = (rd_val != 8'd0) ? grdc_pkg::S_FINISH : grdc_pkg::S_WALK;
			grdc_pkg::S_FINISH:   if (load_out) state_d = grdc_pkg::S_IDLE;
			default:              state_d = grdc_pkg::S_CLEAR;
		endcase
	end

	always_comb begin
		req.ready        = (state_q == grdc_pkg::S_IDLE);
		cfg.ready        = 1'b1;
		div_ctl.start    = (state_q == grdc_pkg::S_CAM_DIV) || (state_q == grdc_pkg::S_RX_DIV) ||
			(state_q == grdc_pkg::S_RY_DIV);
		div_ctl.dividend = grdc_pkg::DIV_N'(31'h4000_0000);
		div_ctl.divisor  = abs_x;
		unique case (state_q)
			grdc_pkg::S_CAM_DIV: begin
				div_ctl.dividend = grdc_pkg::DIV_N'({col_q, 15'd0});
				div_ctl.divisor  = grdc_pkg::DVS_W'(sw_eff);
			end
			grdc_pkg::S_RY_DIV: div_ctl.divisor = abs_y;
			default: ;
		endcase
		mem_we    = 1'b0;
		mem_waddr = req.cell_index;
		mem_wdata = req.cell_value;
		if (state_q == grdc_pkg::S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q[grdc_pkg::MAP_AW-1:0];
			mem_wdata = 8'd0;
		end else if (req.valid && req.ready && req.action == grdc_pkg::ACT_WRITE) begin
			mem_we = 1'b1;
		end
		mem_raddr = nidx[grdc_pkg::MAP_AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= grdc_pkg::S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			pos_x_q     <= 21'd1048576;
			pos_y_q     <= 21'd1048576;
			dir_x_q     <= 16'sd16384;
			dir_y_q     <= 16'sd0;
			plane_x_q   <= 16'sd0;
			plane_y_q   <= 16'sd10813;
			sw_q        <= 13'd640;
		end else begin
			state_q <= state_d;
			if (state_q == grdc_pkg::S_CLEAR) clr_q <= clr_q + 1'b1;
			if (load_out) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.reg_index)
					grdc_pkg::CFG_POS_X:    pos_x_q   <= cfg.data;
					grdc_pkg::CFG_POS_Y:    pos_y_q   <= cfg.data;
					grdc_pkg::CFG_DIR_X:    dir_x_q   <= cfg.data[15:0];
					grdc_pkg::CFG_DIR_Y:    dir_y_q   <= cfg.data[15:0];
					grdc_pkg::CFG_PLANE_X:  plane_x_q <= cfg.data[15:0];
					grdc_pkg::CFG_PLANE_Y:  plane_y_q <= cfg.data[15:0];
					grdc_pkg::CFG_SCREEN_W: sw_q      <= cfg.data[12:0];
					default: ;
				endcase
			end
		end
	end

	// cast datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			grdc_pkg::S_IDLE: begin
				col_q  <= req.column;
				stat_q <= grdc_pkg::STAT_LIMIT;
				side_q <= grdc_pkg::SIDE_WEST;
				perp_q <= '0;
				wall_q <= '0;
				step_q <= '0;
			end
			grdc_pkg::S_CAM_WAIT:
				if (div_sts.done) cam_q <= $signed({1'b0, div_sts.quotient[27:0]}) - 29'sd16384;
			grdc_pkg::S_MUL_X: prod_q <= mul_p;
			grdc_pkg::S_MUL_Y: begin
				rdx_q  <= rd_sat;
				prod_q <= mul_p;
			end
			grdc_pkg::S_RX_DIV: rdy_q <= rd_sat;
			grdc_pkg::S_RX_WAIT:
				if (div_sts.done) dx_q <= (rdx_q == '0) ? 32'hFFFF_FFFF : 32'(div_sts.quotient);
			grdc_pkg::S_RY_WAIT:
				if (div_sts.done) dy_q <= (rdy_q == '0) ? 32'hFFFF_FFFF : 32'(div_sts.quotient);
			grdc_pkg::S_SDX_MUL: prod_q <= mul_p;
			grdc_pkg::S_SDY_MUL: begin
				sdx_q  <= sd_sat;
				prod_q <= mul_p;
				cx_q   <= grdc_pkg::CRD_W'(pos_x_q[20:16]);
				cy_q   <= grdc_pkg::CRD_W'(pos_y_q[20:16]);
			end
			grdc_pkg::S_SIDE: begin
				sdy_q <= sd_sat;
				if (!start_in) stat_q <= grdc_pkg::STAT_LEFT;
			end
			grdc_pkg::S_WALK:
				if (step_q != grdc_pkg::STEP_W'(grdc_pkg::MAX_STEPS)) begin
					step_q <= step_q + 1'b1;
					cx_q   <= nx;
					cy_q   <= ny;
					oob_q  <= nidx >= grdc_pkg::IDX_W'(grdc_pkg::MAP_DEPTH);
					if (take_x) begin
						perp_q <= sdx_q;
						sdx_q  <= acc_sat;
						side_q <= rdx_q[16] ? grdc_pkg::SIDE_WEST : grdc_pkg::SIDE_EAST;
					end else begin
						perp_q <= sdy_q;
						sdy_q  <= acc_sat;
						side_q <= rdy_q[16] ? grdc_pkg::SIDE_SOUTH : grdc_pkg::SIDE_NORTH;
					end
					if (!next_in) stat_q <= grdc_pkg::STAT_LEFT;
				end
			grdc_pkg::S_READ:
				if (rd_val != 8'd0) begin
					stat_q <= grdc_pkg::STAT_HIT;
					wall_q <= rd_val;
				end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (load_out) begin
			rsp.column_out <= col_q;
			rsp.ray_dir_x  <= rdx_q;
			rsp.ray_dir_y  <= rdy_q;
			rsp.hit_cell_x <= cx_q[4:0];
			rsp.hit_cell_y <= cy_q[4:0];
			rsp.side       <= side_q;
			rsp.perp_dist  <= perp_q;
			rsp.wall_value <= wall_q;
			rsp.status     <= stat_q;
		end
	end

	assign rsp.valid = out_valid_q;

	`GRDC_ASSERT_IMP(a_clear_blocks, clk, arst_n, state_q == grdc_pkg::S_CLEAR, !req.ready)
	`GRDC_ASSERT_IMP(a_div_idle_start, clk, arst_n, div_ctl.start, !div_sts.busy)
	`GRDC_ASSERT_IMP(a_step_bound, clk, arst_n, state_q == grdc_pkg::S_WALK, step_q <= grdc_pkg::STEP_W'(grdc_pkg::MAX_STEPS))
	`GRDC_ASSERT_NXT(a_hit_has_wall, clk, arst_n, load_out && stat_q == grdc_pkg::STAT_HIT, rsp.wall_value != 8'd0)
endmodule

/* tb/tb_grid_ray_dda_caster.sv */
// ----------------------------------------------------------------------------
// Grid raycaster testbench
// Drives map writes and column casts through the request channel, changes
// the camera registers between phases, predicts each ray walk in a shadow
// model, and compares every result transfer field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_grid_ray_dda_caster;

	typedef struct packed {
		logic [11:0]        column_out;
		logic signed [16:0] ray_dir_x;
		logic signed [16:0] ray_dir_y;
		logic [4:0]         hit_cell_x;
		logic [4:0]         hit_cell_y;
		logic [1:0]         side;
		logic [31:0]        perp_dist;
		logic [7:0]         wall_value;
		logic [1:0]         status;
	} ray_hit_t;

	logic clk;
	logic arst_n;

	grdc_req_if req_ch ();
	grdc_rsp_if rsp_ch ();
	grdc_cfg_if cfg_ch ();

	grid_ray_dda_caster dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// shadow copy of the map and camera registers
	logic [7:0]         map_shadow [grdc_pkg::MAP_DEPTH];
	logic [20:0]        cam_pos_x, cam_pos_y;
	logic signed [15:0] cam_dir_x, cam_dir_y, cam_plane_x, cam_plane_y;
	logic [12:0]        cam_screen_w;

	ray_hit_t hit_q [$];
	int       err_count;
	bit       calm;        // no idling on either side
	int       hold_req;    // receiver hold-off request, in cycles

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic longint clamp17(longint v);
		if (v < -65536) return -65536;
		if (v > 65535) return 65535;
		return v;
	endfunction

	function automatic longint clamp32(longint v);
		return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
	endfunction

	function automatic longint inv_step(longint rd);
		if (rd == 0) return 64'hFFFF_FFFF;
		return (64'd1 << 30) / ((rd < 0) ? -rd : rd);
	endfunction

	function automatic bit on_map(longint x, longint y);
		return x >= 0 && x < grdc_pkg::MAP_COLS && y >= 0 && y < grdc_pkg::MAP_ROWS;
	endfunction

	function automatic ray_hit_t trace_column(logic [11:0] col);
		ray_hit_t r;
		longint sw, cam, rdx, rdy, ddx, ddy, sdx, sdy, cx, cy, perp, fx, fy;
		logic [1:0] sd;
		logic [1:0] st;
		logic [7:0] wl;
		sw   = (cam_screen_w == 0) ? 1 : cam_screen_w;
		cam  = (longint'(col) * 32768) / sw - 16384;
		rdx  = clamp17(longint'(cam_dir_x) + ((longint'(cam_plane_x) * cam) >>> 14));
		rdy  = clamp17(longint'(cam_dir_y) + ((longint'(cam_plane_y) * cam) >>> 14));
		ddx  = inv_step(rdx);
		ddy  = inv_step(rdy);
		cx   = cam_pos_x[20:16];
		cy   = cam_pos_y[20:16];
		fx   = cam_pos_x[15:0];
		fy   = cam_pos_y[15:0];
		sdx  = clamp32((((rdx < 0) ? fx : 65536 - fx) * ddx) >> 16);
		sdy  = clamp32((((rdy < 0) ? fy : 65536 - fy) * ddy) >> 16);
		perp = 0;
		sd   = grdc_pkg::SIDE_WEST;
		st   = grdc_pkg::STAT_LIMIT;
		wl   = 8'd0;
		if (!on_map(cx, cy)) begin
			st = grdc_pkg::STAT_LEFT;
		end else begin
			for (int n = 0; n < grdc_pkg::MAX_STEPS; n++) begin
				if (sdx < sdy) begin
					perp = sdx;
					sdx  = clamp32(sdx + ddx);
					cx   = (rdx < 0) ? cx - 1 : cx + 1;
					sd   = (rdx < 0) ? grdc_pkg::SIDE_WEST : grdc_pkg::SIDE_EAST;
				end else begin
					perp = sdy;
					sdy  = clamp32(sdy + ddy);
					cy   = (rdy < 0) ? cy - 1 : cy + 1;
					sd   = (rdy < 0) ? grdc_pkg::SIDE_SOUTH : grdc_pkg::SIDE_NORTH;
				end
				if (!on_map(cx, cy)) begin
					st = grdc_pkg::STAT_LEFT;
					break;
				end
				if (map_shadow[cx + cy * grdc_pkg::MAP_COLS] != 0) begin
					st = grdc_pkg::STAT_HIT;
					wl = map_shadow[cx + cy * grdc_pkg::MAP_COLS];
					break;
				end
			end
		end
		r.column_out = col;
		r.ray_dir_x  = rdx[16:0];
		r.ray_dir_y  = rdy[16:0];
		r.hit_cell_x = cx[4:0];
		r.hit_cell_y = cy[4:0];
		r.side       = sd;
		r.perp_dist  = perp[31:0];
		r.wall_value = wl;
		r.status     = st;
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		err_count++;
	endtask

	// result side: random stalls, optional long hold-off, in-order compare
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (hit_q.size() == 0) begin
					report_mismatch("result transfer with nothing expected");
				end else begin
					ray_hit_t e;
					e = hit_q.pop_front();
					if (rsp_ch.column_out !== e.column_out)
						report_mismatch($sformatf("column_out %0d exp %0d",
							rsp_ch.column_out, e.column_out));
					if (rsp_ch.ray_dir_x !== e.ray_dir_x)
						report_mismatch($sformatf("col %0d ray_dir_x %0d exp %0d",
							e.column_out, rsp_ch.ray_dir_x, e.ray_dir_x));
					if (rsp_ch.ray_dir_y !== e.ray_dir_y)
						report_mismatch($sformatf("col %0d ray_dir_y %0d exp %0d",
							e.column_out, rsp_ch.ray_dir_y, e.ray_dir_y));
					if (rsp_ch.hit_cell_x !== e.hit_cell_x)
						report_mismatch($sformatf("col %0d hit_cell_x %0d exp %0d",
							e.column_out, rsp_ch.hit_cell_x, e.hit_cell_x));
					if (rsp_ch.hit_cell_y !== e.hit_cell_y)
						report_mismatch($sformatf("col %0d hit_cell_y %0d exp %0d",
							e.column_out, rsp_ch.hit_cell_y, e.hit_cell_y));
					if (rsp_ch.side !== e.side)
						report_mismatch($sformatf("col %0d side %0d exp %0d",
							e.column_out, rsp_ch.side, e.side));
					if (rsp_ch.perp_dist !== e.perp_dist)
						report_mismatch($sformatf("col %0d perp_dist %0h exp %0h",
							e.column_out, rsp_ch.perp_dist, e.perp_dist));
					if (rsp_ch.wall_value !== e.wall_value)
						report_mismatch($sformatf("col %0d wall_value %0d exp %0d",
							e.column_out, rsp_ch.wall_value, e.wall_value));
					if (rsp_ch.status !== e.status)
						report_mismatch($sformatf("col %0d status %0d exp %0d",
							e.column_out, rsp_ch.status, e.status));
				end
			end
			if (hold_req > 0) begin
				hold_req     <= hold_req - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= calm || ($urandom_range(99) >= 21);
			end
		end
	end

	// leaves valid high afterwards unless a gap is taken
	task automatic send_item(logic act, logic [9:0] idx, logic [7:0] val, logic [11:0] col);
		req_ch.valid      <= 1'b1;
		req_ch.action     <= act;
		req_ch.cell_index <= idx;
		req_ch.cell_value <= val;
		req_ch.column     <= col;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (act == grdc_pkg::ACT_WRITE) map_shadow[idx] = val;
		else hit_q.push_back(trace_column(col));
		if (!calm && $urandom_range(99) < 21) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain();
		int guard;
		req_ch.valid <= 1'b0;
		guard = 0;
		while (hit_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		// a trailing write may still be in flight
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [20:0] val);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.data      <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		case (idx)
			grdc_pkg::CFG_POS_X:    cam_pos_x    = val;
			grdc_pkg::CFG_POS_Y:    cam_pos_y    = val;
			grdc_pkg::CFG_DIR_X:    cam_dir_x    = val[15:0];
			grdc_pkg::CFG_DIR_Y:    cam_dir_y    = val[15:0];
			grdc_pkg::CFG_PLANE_X:  cam_plane_x  = val[15:0];
			grdc_pkg::CFG_PLANE_Y:  cam_plane_y  = val[15:0];
			grdc_pkg::CFG_SCREEN_W: cam_screen_w = val[12:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_camera(logic [20:0] px, logic [20:0] py, logic [15:0] dx,
		logic [15:0] dy, logic [15:0] plx, logic [15:0] ply, logic [12:0] sw);
		write_reg(grdc_pkg::CFG_POS_X, px);
		write_reg(grdc_pkg::CFG_POS_Y, py);
		write_reg(grdc_pkg::CFG_DIR_X, {5'd0, dx});
		write_reg(grdc_pkg::CFG_DIR_Y, {5'd0, dy});
		write_reg(grdc_pkg::CFG_PLANE_X, {5'd0, plx});
		write_reg(grdc_pkg::CFG_PLANE_Y, {5'd0, ply});
		write_reg(grdc_pkg::CFG_SCREEN_W, {8'd0, sw});
	endtask

	task automatic random_cast();
		logic [11:0] col;
		int sw;
		sw  = (cam_screen_w == 0) ? 1 : cam_screen_w;
		col = ($urandom_range(99) < 90) ? 12'($urandom_range(sw > 4096 ? 4095 : sw - 1, 0))
			: 12'($urandom_range(4095));
		send_item(grdc_pkg::ACT_CAST, 10'($urandom), 8'($urandom), col);
	endtask

	// empty map with reset camera: every ray leaves the map
	task automatic test_reset_camera();
		send_item(grdc_pkg::ACT_CAST, 10'd0, 8'd0, 12'd0);
		send_item(grdc_pkg::ACT_CAST, 10'd1023, 8'd255, 12'd320);
		send_item(grdc_pkg::ACT_CAST, 10'd0, 8'd0, 12'd639);
		drain();
	endtask

	// sparse walls on the first and last rows, extremes of columns, zero width, axis-aligned rays
	task automatic test_directed();
		for (int i = 0; i < 32; i += 4) begin
			send_item(grdc_pkg::ACT_WRITE, 10'(i), 8'd255, 12'd0);
			send_item(grdc_pkg::ACT_WRITE, 10'(i + 31 * grdc_pkg::MAP_COLS), 8'(i + 1), 12'd4095);
		end
		send_item(grdc_pkg::ACT_WRITE, 10'd1023, 8'd255, 12'd0);
		send_item(grdc_pkg::ACT_CAST, 10'd0, 8'd0, 12'd4095);
		drain();
		set_camera(21'h1FFFFF, 21'd0, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 13'd0);
		send_item(grdc_pkg::ACT_CAST, 10'd0, 8'd0, 12'd0);
		send_item(grdc_pkg::ACT_CAST, 10'd0, 8'd0, 12'd1);
		send_item(grdc_pkg::ACT_CAST, 10'd0, 8'd0, 12'd4095);
		drain();
		set_camera(21'h100000, 21'h108000, 16'd0, 16'h4000, 16'd0, 16'd0, 13'd4096);
		send_item(grdc_pkg::ACT_CAST, 10'd0, 8'd0, 12'd2048);
		send_item(grdc_pkg::ACT_CAST, 10'd0, 8'd0, 12'd0);
		drain();
		set_camera(21'h0F8000, 21'h100000, 16'h0, 16'h0, 16'h0, 16'h0, 13'h1FFF);
		send_item(grdc_pkg::ACT_CAST, 10'd0, 8'd0, 12'd100);
		drain();
	endtask

	task automatic random_camera();
		set_camera(21'($urandom), 21'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom),
			($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(700, 1)));
	endtask

	// phases of random walls and casts, each with a new camera
	task automatic test_random_scenes();
		for (int ph = 0; ph < 14; ph++) begin
			calm = (ph == 5);
			random_camera();
			for (int k = 0; k < 55; k++) begin
				if ($urandom_range(99) < 30)
					send_item(grdc_pkg::ACT_WRITE, 10'($urandom),
						($urandom_range(3) == 0) ? 8'd0 : 8'($urandom), 12'($urandom));
				else
					random_cast();
			end
			drain();
		end
		calm = 1'b0;
	endtask

	// receiver holds off while casts keep coming, then the sender waits it out
	task automatic test_backpressure();
		hold_req = 400;
		for (int k = 0; k < 12; k++) random_cast();
		drain();
		for (int k = 0; k < 6; k++) random_cast();
		drain();
	endtask

	initial begin
		arst_n           = 1'b0;
		calm             = 1'b0;
		hold_req         = 0;
		err_count        = 0;
		req_ch.valid     = 1'b0;
		req_ch.action    = grdc_pkg::ACT_WRITE;
		req_ch.cell_index = '0;
		req_ch.cell_value = '0;
		req_ch.column    = '0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.reg_index = grdc_pkg::CFG_POS_X;
		cfg_ch.data      = '0;
		foreach (map_shadow[i]) map_shadow[i] = 8'd0;
		cam_pos_x    = 21'd1048576;
		cam_pos_y    = 21'd1048576;
		cam_dir_x    = 16'sd16384;
		cam_dir_y    = 16'sd0;
		cam_plane_x  = 16'sd0;
		cam_plane_y  = 16'sd10813;
		cam_screen_w = 13'd640;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_camera();
		test_directed();
		test_random_scenes();
		test_backpressure();

		drain();
		repeat (300) @(posedge clk);
		if (err_count == 0 && hit_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#60ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
